@@ rtl/rsps_pkg.sv @@
// ----------------------------------------------------------------------------
// rsps_pkg
// Types, constants and the station to port table shared by the steering
// logic and its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsps_pkg;

   localparam int FREE_COUNT_MAX = 63;
   localparam int MAX_CANDIDATES = 4;
   localparam int CAND_FIELDS    = 4;

   localparam int COUNT_W     = 6;
   localparam int PORT_W      = 3;
   localparam int STATION_W   = 3;
   localparam int CLASS_W     = 3;
   localparam int CAND_CNT_W  = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int NUM_PORTS   = 1 << PORT_W;
   localparam int NUM_FREE    = 4;

   localparam int COUNT_ALL_ONES = (1 << COUNT_W) - 1;
   localparam int CAND_LIMIT     = (MAX_CANDIDATES < CAND_FIELDS) ? MAX_CANDIDATES
                                                                 : CAND_FIELDS;
   localparam logic [COUNT_W-1:0] FREE_CAP =
      COUNT_W'((FREE_COUNT_MAX < COUNT_ALL_ONES) ? FREE_COUNT_MAX : COUNT_ALL_ONES);
   localparam logic [CAND_CNT_W-1:0] CAND_LIMIT_CNT = CAND_CNT_W'(CAND_LIMIT);

   localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(4);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_EXEC_SURPLUS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXEC_IMBALANCE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDR_SURPLUS   = 2'd2;

   // station codes
   localparam logic [STATION_W-1:0] STATION_EXEC_ZERO = 3'd0;
   localparam logic [STATION_W-1:0] STATION_EXEC_ONE  = 3'd1;
   localparam logic [STATION_W-1:0] STATION_ADDR_ZERO = 3'd2;
   localparam logic [STATION_W-1:0] STATION_ADDR_ONE  = 3'd3;
   localparam logic [STATION_W-1:0] STATION_BRANCH    = 3'd4;

   typedef enum logic [0:0] {
      OP_TICK  = 1'b0,
      OP_ALLOC = 1'b1
   } op_type;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_ANY       = 3'd0,
      CLASS_EXEC_PAIR = 3'd1,
      CLASS_ADDR_PAIR = 3'd2,
      CLASS_EXEC_ZERO = 3'd3,
      CLASS_EXEC_ONE  = 3'd4,
      CLASS_BRANCH    = 3'd5
   } class_type;

   typedef struct packed {
      logic [COUNT_W-1:0] exec_surplus;
      logic [COUNT_W-1:0] exec_imbalance;
      logic [COUNT_W-1:0] addr_surplus;
   } thresholds_type;

   typedef struct packed {
      logic [NUM_FREE-1:0][COUNT_W-1:0] free_counts;
      logic                             exec_main;
      logic                             addr_main;
      logic [1:0]                       slot;
   } steer_state_type;

   typedef struct packed {
      logic [CLASS_W-1:0]                  station_class;
      logic [CAND_FIELDS-1:0][PORT_W-1:0]  ports;
      logic [CAND_CNT_W-1:0]               count;
   } alloc_item_type;

   typedef struct packed {
      logic [PORT_W-1:0]    port;
      logic [STATION_W-1:0] station;
      logic                 error;
      logic                 advance_slot;
   } steer_result_type;

   function automatic logic port_on_station(input logic [STATION_W-1:0] station,
                                            input logic [PORT_W-1:0]    port);
      logic [NUM_PORTS-1:0] mask;
      begin
         case (station)
            STATION_EXEC_ZERO: mask = 8'h07;
            STATION_EXEC_ONE:  mask = 8'h18;
            STATION_ADDR_ZERO: mask = 8'h20;
            STATION_ADDR_ONE:  mask = 8'h40;
            STATION_BRANCH:    mask = 8'h80;
            default:           mask = '0;
         endcase
         port_on_station = mask[port];
      end
   endfunction

   function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] value);
      begin
         sat_count = (value > FREE_CAP) ? FREE_CAP : value;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/rsps_steer.sv @@
// ----------------------------------------------------------------------------
// rsps_steer
// Station choice from class, free counts, thresholds and the dispatch slot, then
// search of the candidate ports for the first one served by that station.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsps_steer (
   input  wire rsps_pkg::thresholds_type   thresholds,
   input  wire rsps_pkg::steer_state_type  state,
   input  wire rsps_pkg::alloc_item_type   item,
   output rsps_pkg::steer_result_type      result
);

   import rsps_pkg::*;

   logic [COUNT_W-1:0]   e0, e1, a0, a1;
   logic [COUNT_W:0]     exec_sum, addr_sum;
   logic                 exec_favoured, addr_favoured, exec_imbalanced;
   logic                 exec_peak_wins;
   logic [STATION_W-1:0] em, ef, am, af;
   logic [STATION_W-1:0] station;
   logic                 class_valid;
   logic [CAND_CNT_W-1:0] cnt_sat;
   logic                 found;
   logic [PORT_W-1:0]    port;

   always_comb begin
      e0 = state.free_counts[0];
      e1 = state.free_counts[1];
      a0 = state.free_counts[2];
      a1 = state.free_counts[3];
      exec_sum = {1'b0, e0} + {1'b0, e1};
      addr_sum = {1'b0, a0} + {1'b0, a1};
      exec_favoured   = (COUNT_W+2)'(exec_sum) >=
                        ((COUNT_W+2)'(addr_sum) + (COUNT_W+2)'(thresholds.exec_surplus));
      addr_favoured   = (COUNT_W+2)'(addr_sum) >=
                        ((COUNT_W+2)'(exec_sum) + (COUNT_W+2)'(thresholds.addr_surplus));
      exec_imbalanced = {1'b0, e0} >= ({1'b0, e1} + {1'b0, thresholds.exec_imbalance});
      exec_peak_wins  = ((e0 > e1) ? e0 : e1) >= ((a0 > a1) ? a0 : a1);

      em = state.exec_main ? STATION_EXEC_ONE : STATION_EXEC_ZERO;
      ef = state.exec_main ? STATION_EXEC_ZERO : STATION_EXEC_ONE;
      am = state.addr_main ? STATION_ADDR_ONE : STATION_ADDR_ZERO;
      af = state.addr_main ? STATION_ADDR_ZERO : STATION_ADDR_ONE;

      class_valid = 1'b1;
      station     = STATION_EXEC_ZERO;
      case (item.station_class)
         CLASS_ANY: begin
            if (exec_favoured) begin
               station = (exec_imbalanced || !state.slot[0]) ? em : ef;
            end else if (addr_favoured) begin
               station = state.slot[0] ? af : am;
            end else begin
               case (state.slot)
                  2'd0:    station = exec_peak_wins ? em : am;
                  2'd1:    station = exec_peak_wins ? ef : af;
                  2'd2:    station = exec_peak_wins ? am : em;
                  default: station = exec_peak_wins ? af : ef;
               endcase
            end
         end
         CLASS_EXEC_PAIR: begin
            if (e0 > e1 && e1 == '0) begin
               station = STATION_EXEC_ZERO;
            end else if (e1 > e0 && e0 == '0) begin
               station = STATION_EXEC_ONE;
            end else begin
               station = state.slot[0] ? STATION_EXEC_ONE : STATION_EXEC_ZERO;
            end
         end
         CLASS_ADDR_PAIR: begin
            if (a0 > a1 && a1 == '0) begin
               station = STATION_ADDR_ZERO;
            end else if (a1 > a0 && a0 == '0) begin
               station = STATION_ADDR_ONE;
            end else begin
               station = state.slot[0] ? STATION_ADDR_ONE : STATION_ADDR_ZERO;
            end
         end
         CLASS_EXEC_ZERO: station = STATION_EXEC_ZERO;
         CLASS_EXEC_ONE:  station = STATION_EXEC_ONE;
         CLASS_BRANCH:    station = STATION_BRANCH;
         default:         class_valid = 1'b0;
      endcase

      // first candidate in preference order served by the station
      cnt_sat = (item.count > CAND_LIMIT_CNT) ? CAND_LIMIT_CNT : item.count;
      found   = 1'b0;
      port    = '0;
      for (int i = 0; i < CAND_FIELDS; i++) begin
         if (!found && (CAND_CNT_W'(i) < cnt_sat)
             && port_on_station(station, item.ports[i])) begin
            found = 1'b1;
            port  = item.ports[i];
         end
      end

      result.port         = (class_valid && found) ? port : '0;
      result.station      = class_valid ? station : STATION_EXEC_ZERO;
      result.error        = !(class_valid && found);
      result.advance_slot = class_valid;
   end

endmodule

`default_nettype wire

@@ rtl/reservation_station_port_steering_top.sv @@
// ----------------------------------------------------------------------------
// reservation_station_port_steering_top
// Steers allocated instructions to a reservation station and issue port;
// tick items reload the station free counts and main stations and clear the dispatch slot.
// ----------------------------------------------------------------------------
// pipeline: an allocate item passes the input register, then the result
// register, before its result shows; a tick item gives no result
// throughput: one item per cycle unless a stalled result holds back an allocate
// item, set by the single steering pass between the input and result registers
// reset: synchronous; thresholds return to 4, free counts, main stations and
// the slot counter clear, both stages empty
`timescale 1ns / 1ps
`default_nettype none

module reservation_station_port_steering_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [rsps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rsps_pkg::COUNT_W-1:0]     csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_operation,
   input  wire logic [rsps_pkg::COUNT_W-1:0]     req_free_exec_zero,
   input  wire logic [rsps_pkg::COUNT_W-1:0]     req_free_exec_one,
   input  wire logic [rsps_pkg::COUNT_W-1:0]     req_free_addr_zero,
   input  wire logic [rsps_pkg::COUNT_W-1:0]     req_free_addr_one,
   input  wire logic [rsps_pkg::CLASS_W-1:0]     req_station_class,
   input  wire logic [rsps_pkg::PORT_W-1:0]      req_candidate_port_a,
   input  wire logic [rsps_pkg::PORT_W-1:0]      req_candidate_port_b,
   input  wire logic [rsps_pkg::PORT_W-1:0]      req_candidate_port_c,
   input  wire logic [rsps_pkg::PORT_W-1:0]      req_candidate_port_d,
   input  wire logic [rsps_pkg::CAND_CNT_W-1:0]  req_candidate_count,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [rsps_pkg::PORT_W-1:0]           rsp_chosen_port,
   output logic [rsps_pkg::STATION_W-1:0]        rsp_chosen_station,
   output logic                                  rsp_steer_error
);

   import rsps_pkg::*;

   thresholds_type   thresholds_ff, thresholds_in;
   steer_state_type  state_ff, state_in;

   logic             s1_valid_ff, s1_valid_in;
   op_type           s1_op_ff, s1_op_in;
   logic [NUM_FREE-1:0][COUNT_W-1:0] s1_free_ff, s1_free_in;
   alloc_item_type   s1_item_ff, s1_item_in;

   logic             rsp_valid_ff, rsp_valid_in;
   steer_result_type rsp_result_ff, rsp_result_in;

   steer_result_type steer_result;
   logic             s1_needs_out;
   logic             s1_advance;
   logic [NUM_FREE-1:0][COUNT_W-1:0] free_sat;

   rsps_steer u_steer (
      .thresholds (thresholds_ff),
      .state      (state_ff),
      .item       (s1_item_ff),
      .result     (steer_result)
   );

   always_comb begin
      s1_needs_out = (s1_op_ff == OP_ALLOC);
      s1_advance   = s1_valid_ff && (!s1_needs_out || !rsp_valid_ff || !rsp_stall);
      req_stall    = s1_valid_ff && !s1_advance;

      // input register
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_free_in  = s1_free_ff;
      s1_item_in  = s1_item_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_op_in    = op_type'(req_operation);
         s1_free_in  = {req_free_addr_one, req_free_addr_zero,
                        req_free_exec_one, req_free_exec_zero};
         s1_item_in.station_class = req_station_class;
         s1_item_in.ports = {req_candidate_port_d, req_candidate_port_c,
                             req_candidate_port_b, req_candidate_port_a};
         s1_item_in.count = req_candidate_count;
      end

      // steering state
      for (int i = 0; i < NUM_FREE; i++) begin
         free_sat[i] = sat_count(s1_free_ff[i]);
      end
      state_in = state_ff;
      if (s1_advance) begin
         if (s1_op_ff == OP_TICK) begin
            state_in.free_counts = free_sat;
            state_in.exec_main   = !(free_sat[0] >= free_sat[1]);
            state_in.addr_main   = !(free_sat[2] >= free_sat[3]);
            state_in.slot        = '0;
         end else if (steer_result.advance_slot) begin
            state_in.slot = state_ff.slot + 2'd1;
         end
      end

      // result register
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (s1_advance && s1_needs_out) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = steer_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // configuration
      thresholds_in = thresholds_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EXEC_SURPLUS:   thresholds_in.exec_surplus   = csr_write_data;
            CSR_EXEC_IMBALANCE: thresholds_in.exec_imbalance = csr_write_data;
            CSR_ADDR_SURPLUS:   thresholds_in.addr_surplus   = csr_write_data;
            default:            thresholds_in = thresholds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff <= '{exec_surplus:   THRESHOLD_RESET,
                            exec_imbalance: THRESHOLD_RESET,
                            addr_surplus:   THRESHOLD_RESET};
         state_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         thresholds_ff <= thresholds_in;
         state_ff      <= state_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff      <= s1_op_in;
      s1_free_ff    <= s1_free_in;
      s1_item_ff    <= s1_item_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_port    = rsp_result_ff.port;
   assign rsp_chosen_station = rsp_result_ff.station;
   assign rsp_steer_error    = rsp_result_ff.error;

   // a clean result always names a port served by its station
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_result_ff.error
         |-> port_on_station(rsp_result_ff.station, rsp_result_ff.port))
      else $error("steered port not served by station");

   // a failed steer reports port zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_ff.error |-> rsp_result_ff.port == '0)
      else $error("error result with nonzero port");

   // the input side only holds off while an allocate item in the input register waits on a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_op_ff == OP_ALLOC && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   // a tick leaves the slot counter cleared
   assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_op_ff == OP_TICK |=> state_ff.slot == '0)
      else $error("slot counter not cleared by tick");

   // no result appears straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

`default_nettype wire

@@ dv/steering_checker.sv @@
// ----------------------------------------------------------------------------
// steering_checker
// Watches the request, result and register ports of the port steering block.
// Keeps its own copy of the free counts, main stations, dispatch slot and
// thresholds, works out the station and port that each allocate item should
// get, and compares every result in order against those outcomes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module steering_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [rsps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rsps_pkg::COUNT_W-1:0]     csr_write_data,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_operation,
   input  logic [rsps_pkg::COUNT_W-1:0]     req_free_exec_zero,
   input  logic [rsps_pkg::COUNT_W-1:0]     req_free_exec_one,
   input  logic [rsps_pkg::COUNT_W-1:0]     req_free_addr_zero,
   input  logic [rsps_pkg::COUNT_W-1:0]     req_free_addr_one,
   input  logic [rsps_pkg::CLASS_W-1:0]     req_station_class,
   input  logic [rsps_pkg::PORT_W-1:0]      req_candidate_port_a,
   input  logic [rsps_pkg::PORT_W-1:0]      req_candidate_port_b,
   input  logic [rsps_pkg::PORT_W-1:0]      req_candidate_port_c,
   input  logic [rsps_pkg::PORT_W-1:0]      req_candidate_port_d,
   input  logic [rsps_pkg::CAND_CNT_W-1:0]  req_candidate_count,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [rsps_pkg::PORT_W-1:0]      rsp_chosen_port,
   input  logic [rsps_pkg::STATION_W-1:0]   rsp_chosen_station,
   input  logic                             rsp_steer_error,
   output int                               steers_pending,
   output int                               mismatch_count
);

   import rsps_pkg::*;

   typedef struct packed {
      logic [PORT_W-1:0]    port;
      logic [STATION_W-1:0] station;
      logic                 error;
   } steer_outcome_type;

   // issue ports served by each station, branch station on top
   localparam logic [4:0][NUM_PORTS-1:0] STATION_PORTS =
      {8'h80, 8'h40, 8'h20, 8'h18, 8'h07};

   logic [COUNT_W-1:0] thr_exec_surplus;
   logic [COUNT_W-1:0] thr_exec_imbalance;
   logic [COUNT_W-1:0] thr_addr_surplus;
   logic [COUNT_W-1:0] free_cnt [NUM_FREE];
   logic               exec_main;
   logic               addr_main;
   logic [1:0]         slot;

   steer_outcome_type expected_steers [$];
   steer_outcome_type got;
   steer_outcome_type want;

   function automatic logic [COUNT_W-1:0] clamp_free(input logic [COUNT_W-1:0] value);
      return (value > FREE_CAP) ? FREE_CAP : value;
   endfunction

   function automatic logic [STATION_W-1:0] select_station(input logic [CLASS_W-1:0] cls);
      int                   e0, e1, a0, a1;
      int                   exec_lead, exec_peak, addr_peak;
      logic [STATION_W-1:0] em, ef, am, af, lo, hi;
      e0 = free_cnt[0];
      e1 = free_cnt[1];
      a0 = free_cnt[2];
      a1 = free_cnt[3];
      em = STATION_EXEC_ZERO + exec_main;
      ef = em ^ 3'd1;
      am = STATION_ADDR_ZERO + addr_main;
      af = am ^ 3'd1;
      case (cls)
         CLASS_ANY: begin
            exec_lead = (e0 + e1) - (a0 + a1);
            if (exec_lead >= int'(thr_exec_surplus)) begin
               if (e0 - e1 >= int'(thr_exec_imbalance))
                  return em;
               return slot[0] ? ef : em;
            end
            if (-exec_lead >= int'(thr_addr_surplus))
               return slot[0] ? af : am;
            exec_peak = (e0 > e1) ? e0 : e1;
            addr_peak = (a0 > a1) ? a0 : a1;
            // rotate over all four, pair with the larger peak first, exec on a tie
            if (exec_peak >= addr_peak) begin
               case (slot)
                  2'd0: return em;
                  2'd1: return ef;
                  2'd2: return am;
                  default: return af;
               endcase
            end
            case (slot)
               2'd0: return am;
               2'd1: return af;
               2'd2: return em;
               default: return ef;
            endcase
         end
         CLASS_EXEC_PAIR, CLASS_ADDR_PAIR: begin
            lo = (cls == CLASS_ADDR_PAIR) ? STATION_ADDR_ZERO : STATION_EXEC_ZERO;
            hi = lo + 3'd1;
            if (free_cnt[lo[1:0]] > free_cnt[hi[1:0]] && free_cnt[hi[1:0]] == '0)
               return lo;
            if (free_cnt[hi[1:0]] > free_cnt[lo[1:0]] && free_cnt[lo[1:0]] == '0)
               return hi;
            return slot[0] ? hi : lo;
         end
         CLASS_EXEC_ZERO: return STATION_EXEC_ZERO;
         CLASS_EXEC_ONE:  return STATION_EXEC_ONE;
         default:         return STATION_BRANCH;
      endcase
   endfunction

   function automatic void apply_item(
      input logic                  op,
      input logic [COUNT_W-1:0]    f0,
      input logic [COUNT_W-1:0]    f1,
      input logic [COUNT_W-1:0]    f2,
      input logic [COUNT_W-1:0]    f3,
      input logic [CLASS_W-1:0]    cls,
      input logic [PORT_W-1:0]     pa,
      input logic [PORT_W-1:0]     pb,
      input logic [PORT_W-1:0]     pc,
      input logic [PORT_W-1:0]     pd,
      input logic [CAND_CNT_W-1:0] cnt
   );
      logic [PORT_W-1:0] cand [CAND_FIELDS];
      int                limit;
      steer_outcome_type res;
      if (op == OP_TICK) begin
         free_cnt[0] = clamp_free(f0);
         free_cnt[1] = clamp_free(f1);
         free_cnt[2] = clamp_free(f2);
         free_cnt[3] = clamp_free(f3);
         exec_main   = (free_cnt[0] >= free_cnt[1]) ? 1'b0 : 1'b1;
         addr_main   = (free_cnt[2] >= free_cnt[3]) ? 1'b0 : 1'b1;
         slot        = 2'd0;
         return;
      end
      res.port  = '0;
      res.error = 1'b1;
      // invalid class leaves the slot alone
      if (cls > CLASS_BRANCH) begin
         res.station = '0;
         expected_steers.push_back(res);
         return;
      end
      res.station = select_station(cls);
      slot        = slot + 2'd1;
      cand[0] = pa;
      cand[1] = pb;
      cand[2] = pc;
      cand[3] = pd;
      limit = (cnt > CAND_LIMIT) ? CAND_LIMIT : cnt;
      for (int i = 0; i < limit; i++) begin
         if (res.error && STATION_PORTS[res.station][cand[i]]) begin
            res.port  = cand[i];
            res.error = 1'b0;
         end
      end
      expected_steers.push_back(res);
   endfunction

   initial begin
      mismatch_count = 0;
      steers_pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         thr_exec_surplus   = THRESHOLD_RESET;
         thr_exec_imbalance = THRESHOLD_RESET;
         thr_addr_surplus   = THRESHOLD_RESET;
         for (int i = 0; i < NUM_FREE; i++)
            free_cnt[i] = '0;
         exec_main = 1'b0;
         addr_main = 1'b0;
         slot      = 2'd0;
         expected_steers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.port    = rsp_chosen_port;
            got.station = rsp_chosen_station;
            got.error   = rsp_steer_error;
            if (expected_steers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with no item waiting: port %0d station %0d error %0b",
                           $realtime, got.port, got.station, got.error);
            end else begin
               want = expected_steers.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: steer mismatch: expected port %0d station %0d error %0b,",
                               " got port %0d station %0d error %0b"},
                              $realtime, want.port, want.station, want.error,
                              got.port, got.station, got.error);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_EXEC_SURPLUS:   thr_exec_surplus   = csr_write_data;
               CSR_EXEC_IMBALANCE: thr_exec_imbalance = csr_write_data;
               CSR_ADDR_SURPLUS:   thr_addr_surplus   = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            apply_item(req_operation, req_free_exec_zero, req_free_exec_one,
                       req_free_addr_zero, req_free_addr_one, req_station_class,
                       req_candidate_port_a, req_candidate_port_b,
                       req_candidate_port_c, req_candidate_port_d,
                       req_candidate_count);
      end
      steers_pending <= expected_steers.size();
   end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the port steering block with a short directed run over every class,
// the count extremes and the candidate count corners, then four random rounds
// under different threshold settings, the first three setting new sender and
// receiver stall rates. The checker alongside does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import rsps_pkg::*;

   localparam logic [CLASS_W-1:0] CLASS_BAD_LOW  = 3'd6;
   localparam logic [CLASS_W-1:0] CLASS_BAD_HIGH = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COUNT_W-1:0]     csr_write_data;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_operation;
   logic [COUNT_W-1:0]     req_free_exec_zero;
   logic [COUNT_W-1:0]     req_free_exec_one;
   logic [COUNT_W-1:0]     req_free_addr_zero;
   logic [COUNT_W-1:0]     req_free_addr_one;
   logic [CLASS_W-1:0]     req_station_class;
   logic [PORT_W-1:0]      req_candidate_port_a;
   logic [PORT_W-1:0]      req_candidate_port_b;
   logic [PORT_W-1:0]      req_candidate_port_c;
   logic [PORT_W-1:0]      req_candidate_port_d;
   logic [CAND_CNT_W-1:0]  req_candidate_count;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PORT_W-1:0]      rsp_chosen_port;
   logic [STATION_W-1:0]   rsp_chosen_station;
   logic                   rsp_steer_error;

   int send_idle_pct;
   int recv_idle_pct;
   int steers_pending;
   int mismatch_count;

   reservation_station_port_steering_top dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_free_exec_zero   (req_free_exec_zero),
      .req_free_exec_one    (req_free_exec_one),
      .req_free_addr_zero   (req_free_addr_zero),
      .req_free_addr_one    (req_free_addr_one),
      .req_station_class    (req_station_class),
      .req_candidate_port_a (req_candidate_port_a),
      .req_candidate_port_b (req_candidate_port_b),
      .req_candidate_port_c (req_candidate_port_c),
      .req_candidate_port_d (req_candidate_port_d),
      .req_candidate_count  (req_candidate_count),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_chosen_port      (rsp_chosen_port),
      .rsp_chosen_station   (rsp_chosen_station),
      .rsp_steer_error      (rsp_steer_error)
   );

   steering_checker steer_check (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_free_exec_zero   (req_free_exec_zero),
      .req_free_exec_one    (req_free_exec_one),
      .req_free_addr_zero   (req_free_addr_zero),
      .req_free_addr_one    (req_free_addr_one),
      .req_station_class    (req_station_class),
      .req_candidate_port_a (req_candidate_port_a),
      .req_candidate_port_b (req_candidate_port_b),
      .req_candidate_port_c (req_candidate_port_c),
      .req_candidate_port_d (req_candidate_port_d),
      .req_candidate_count  (req_candidate_count),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_chosen_port      (rsp_chosen_port),
      .rsp_chosen_station   (rsp_chosen_station),
      .rsp_steer_error      (rsp_steer_error),
      .steers_pending       (steers_pending),
      .mismatch_count       (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic logic [COUNT_W-1:0] random_free_count();
      case ($urandom_range(9))
         0, 1:    return '0;
         2:       return COUNT_W'(FREE_COUNT_MAX);
         3, 4:    return COUNT_W'($urandom_range(8));
         default: return COUNT_W'($urandom_range(FREE_COUNT_MAX));
      endcase
   endfunction

   task automatic drive_item(
      input logic                  op,
      input logic [COUNT_W-1:0]    f0,
      input logic [COUNT_W-1:0]    f1,
      input logic [COUNT_W-1:0]    f2,
      input logic [COUNT_W-1:0]    f3,
      input logic [CLASS_W-1:0]    cls,
      input logic [PORT_W-1:0]     pa,
      input logic [PORT_W-1:0]     pb,
      input logic [PORT_W-1:0]     pc,
      input logic [PORT_W-1:0]     pd,
      input logic [CAND_CNT_W-1:0] cnt
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_operation        <= op;
      req_free_exec_zero   <= f0;
      req_free_exec_one    <= f1;
      req_free_addr_zero   <= f2;
      req_free_addr_one    <= f3;
      req_station_class    <= cls;
      req_candidate_port_a <= pa;
      req_candidate_port_b <= pb;
      req_candidate_port_c <= pc;
      req_candidate_port_d <= pd;
      req_candidate_count  <= cnt;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // unused fields carry noise
   task automatic send_tick(input logic [COUNT_W-1:0] f0, input logic [COUNT_W-1:0] f1,
                            input logic [COUNT_W-1:0] f2, input logic [COUNT_W-1:0] f3);
      drive_item(OP_TICK, f0, f1, f2, f3, CLASS_W'($urandom_range(7)),
                 PORT_W'($urandom_range(7)), PORT_W'($urandom_range(7)),
                 PORT_W'($urandom_range(7)), PORT_W'($urandom_range(7)),
                 CAND_CNT_W'($urandom_range(7)));
   endtask

   task automatic send_alloc(input logic [CLASS_W-1:0] cls,
                             input logic [PORT_W-1:0] pa, input logic [PORT_W-1:0] pb,
                             input logic [PORT_W-1:0] pc, input logic [PORT_W-1:0] pd,
                             input logic [CAND_CNT_W-1:0] cnt);
      drive_item(OP_ALLOC, COUNT_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom),
                 COUNT_W'($urandom), cls, pa, pb, pc, pd, cnt);
   endtask

   task automatic send_random_item();
      logic [CLASS_W-1:0]    cls;
      logic [CAND_CNT_W-1:0] cnt;
      if ($urandom_range(99) < 20) begin
         send_tick(random_free_count(), random_free_count(),
                   random_free_count(), random_free_count());
      end else begin
         if ($urandom_range(99) < 6)
            cls = CLASS_W'($urandom_range(CLASS_BAD_HIGH, CLASS_BAD_LOW));
         else
            cls = CLASS_W'($urandom_range(CLASS_BRANCH));
         if ($urandom_range(99) < 8)
            cnt = ($urandom_range(3) == 0) ? '0 : CAND_CNT_W'($urandom_range(7, 5));
         else
            cnt = CAND_CNT_W'($urandom_range(4, 1));
         send_alloc(cls, PORT_W'($urandom_range(7)), PORT_W'($urandom_range(7)),
                    PORT_W'($urandom_range(7)), PORT_W'($urandom_range(7)), cnt);
      end
   endtask

   // drain the pipe; ticks give no result so allow the latency on top
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (steers_pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_thresholds(input logic [COUNT_W-1:0] exec_surplus,
                                   input logic [COUNT_W-1:0] exec_imbalance,
                                   input logic [COUNT_W-1:0] addr_surplus);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_EXEC_SURPLUS;
      csr_write_data   <= exec_surplus;
      @(posedge clock);
      csr_index        <= CSR_EXEC_IMBALANCE;
      csr_write_data   <= exec_imbalance;
      @(posedge clock);
      csr_index        <= CSR_ADDR_SURPLUS;
      csr_write_data   <= addr_surplus;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_EXEC_SURPLUS;
      csr_write_data       = '0;
      req_valid            = 1'b0;
      req_operation        = OP_TICK;
      req_free_exec_zero   = '0;
      req_free_exec_one    = '0;
      req_free_addr_zero   = '0;
      req_free_addr_one    = '0;
      req_station_class    = CLASS_ANY;
      req_candidate_port_a = '0;
      req_candidate_port_b = '0;
      req_candidate_port_c = '0;
      req_candidate_port_d = '0;
      req_candidate_count  = '0;
      rsp_stall            = 1'b0;
      send_idle_pct        = 0;
      recv_idle_pct        = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset thresholds, every class, empty and full stations
      send_alloc(CLASS_ANY, 0, 1, 2, 3, 4);
      send_tick(63, 0, 0, 0);
      send_alloc(CLASS_ANY, 3, 4, 0, 7, 4);
      send_alloc(CLASS_ANY, 0, 3, 4, 7, 4);
      send_alloc(CLASS_EXEC_PAIR, 3, 0, 5, 6, 4);
      send_alloc(CLASS_ADDR_PAIR, 5, 6, 7, 0, 4);
      send_alloc(CLASS_EXEC_ZERO, 7, 6, 5, 2, 4);
      send_alloc(CLASS_EXEC_ONE, 0, 1, 2, 3, 3);
      send_alloc(CLASS_BRANCH, 7, 0, 0, 0, 1);
      send_alloc(CLASS_BAD_LOW, 7, 7, 7, 7, 4);
      send_alloc(CLASS_BAD_HIGH, 0, 0, 0, 0, 4);
      send_tick(0, 10, 63, 0);
      send_alloc(CLASS_ANY, 5, 6, 3, 0, 4);
      send_alloc(CLASS_ANY, 5, 6, 3, 0, 4);
      send_alloc(CLASS_EXEC_PAIR, 0, 3, 1, 4, 2);
      send_alloc(CLASS_ADDR_PAIR, 6, 5, 0, 0, 2);
      send_tick(20, 20, 20, 20);
      send_alloc(CLASS_ANY, 0, 3, 5, 6, 0);
      send_alloc(CLASS_ANY, 0, 3, 5, 6, 5);
      send_alloc(CLASS_ANY, 0, 3, 5, 6, 7);
      send_alloc(CLASS_ANY, 7, 6, 5, 4, 6);
      send_tick(63, 63, 63, 63);
      send_alloc(CLASS_BRANCH, 7, 7, 7, 7, 4);
      settle();

      for (int round = 0; round < 4; round++) begin
         case (round)
            0: begin
               send_idle_pct = 16;
               recv_idle_pct = 56;
               write_thresholds('0, '0, '0);
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 16;
               write_thresholds('1, '1, '1);
            end
            2: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               write_thresholds(COUNT_W'($urandom), COUNT_W'($urandom),
                                COUNT_W'($urandom));
            end
            default: begin
               write_thresholds(COUNT_W'($urandom_range(10)), COUNT_W'($urandom_range(10)),
                                COUNT_W'($urandom_range(10)));
            end
         endcase
         repeat (250) send_random_item();
         settle();
      end

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
